// ===== hw/rtl/ready_blocked_job_dispatcher_top_macros.svh =====
// ============================================================================
// Assertion macros for the job dispatcher
// Concurrent assertion wrappers that compile away when NO_ASSERTIONS is set.
// ============================================================================
`ifndef READY_BLOCKED_JOB_DISPATCHER_TOP_MACROS_SVH
`define READY_BLOCKED_JOB_DISPATCHER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge, ignored while reset is high.
`define RBJD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define RBJD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBJD_ASSERT(lbl, clk, rst, prop, msg)
`define RBJD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/rbjd_pkg.sv =====
// ============================================================================
// Job dispatcher package
// Sizes, codes, the job record and the queue pointer helper.
// ============================================================================
package rbjd_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 16;
   localparam int TICK_BITS   = 16;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CNT_BITS-1:0]  CNT_DEPTH = CNT_BITS'(QUEUE_DEPTH);
   localparam logic [CNT_BITS-1:0]  CNT_ONE   = CNT_BITS'(1);
   localparam logic [TICK_BITS-1:0] TICK_ONE  = TICK_BITS'(1);

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_TICK    = 3'd1,
      OP_SWITCH  = 3'd2,
      OP_IO_DONE = 3'd3,
      OP_OTHER   = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      STS_NO_JOBS       = 4'd0,
      STS_ONLY_BLOCKED  = 4'd1,
      STS_SWITCHED      = 4'd2,
      STS_BLOCKED_MOVED = 4'd3,
      STS_BLOCKED_EMPTY = 4'd4,
      STS_UNKNOWN_IRQ   = 4'd5,
      STS_LOADED        = 4'd6,
      STS_DECREMENTED   = 4'd7,
      STS_TO_BLOCKED    = 4'd8,
      STS_FINISHED      = 4'd9,
      STS_ADDED         = 4'd10,
      STS_QUEUE_FULL    = 4'd11
   } status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY   = 2'd0,
      SLOT_ACTIVE  = 2'd1,
      SLOT_RETIRED = 2'd2
   } slot_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_EXEC,
      CTL_MOVE,
      CTL_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [TICK_BITS-1:0] start;
      logic [TICK_BITS-1:0] ticks;
      logic                 io;
   } job_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic exec;
      logic move;
      logic load_rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic io_pending;
      logic can_move;
   } dp_status_type;

   // Circular pointer advance; ptr is below the depth and cnt at most the
   // depth, so one conditional subtract wraps the sum.
   function automatic logic [PTR_BITS-1:0] ptr_add(input logic [PTR_BITS-1:0] ptr,
                                                   input logic [CNT_BITS-1:0] cnt);
      logic [CNT_BITS:0] sum;
      sum = (CNT_BITS+1)'(ptr) + (CNT_BITS+1)'(cnt);
      if (sum >= (CNT_BITS+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_BITS+1)'(QUEUE_DEPTH);
      end
      return sum[PTR_BITS-1:0];
   endfunction

endpackage

// ===== hw/rtl/rbjd_datapath.sv =====
// ============================================================================
// Job dispatcher datapath
// Ready and blocked queues, the running slot and the result register.
// ============================================================================
`include "ready_blocked_job_dispatcher_top_macros.svh"

module rbjd_datapath
   import rbjd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        sts,
   input  logic [2:0]           req_operation,
   input  logic [ID_BITS-1:0]   req_job_id,
   input  logic [TICK_BITS-1:0] req_job_start,
   input  logic [TICK_BITS-1:0] req_job_cpu_ticks,
   input  logic                 req_job_wants_io,
   output logic [3:0]           rsp_status,
   output logic [1:0]           rsp_slot_mode,
   output logic [ID_BITS-1:0]   rsp_cur_id,
   output logic [TICK_BITS-1:0] rsp_cur_start,
   output logic [TICK_BITS-1:0] rsp_cur_cpu_ticks,
   output logic                 rsp_cur_wants_io,
   output logic [CNT_BITS-1:0]  rsp_ready_count,
   output logic [CNT_BITS-1:0]  rsp_blocked_count
);

   job_type ready_mem   [QUEUE_DEPTH];
   job_type blocked_mem [QUEUE_DEPTH];

   op_type              op_ff, op_in;
   job_type             job_ff, job_in;
   logic [PTR_BITS-1:0] ready_head_ff, ready_head_in;
   logic [CNT_BITS-1:0] ready_fill_ff, ready_fill_in;
   logic [PTR_BITS-1:0] blocked_head_ff, blocked_head_in;
   logic [CNT_BITS-1:0] blocked_fill_ff, blocked_fill_in;
   job_type             slot_job_ff, slot_job_in;
   slot_type            slot_mode_ff, slot_mode_in;
   status_type          status_ff, status_in;
   job_type             rd_ready_ff, rd_blocked_ff;
   status_type          rsp_status_ff;
   slot_type            rsp_slot_mode_ff;
   job_type             rsp_job_ff;
   logic [CNT_BITS-1:0] rsp_ready_count_ff, rsp_blocked_count_ff;

   logic                ready_we, blocked_we;
   logic [PTR_BITS-1:0] ready_wa, blocked_wa;
   job_type             ready_wd, blocked_wd;
   logic                ready_full, blocked_full, can_move;
   status_type          idle_sts;

   assign ready_full   = (ready_fill_ff == CNT_DEPTH);
   assign blocked_full = (blocked_fill_ff == CNT_DEPTH);
   assign can_move     = (blocked_fill_ff != '0) && !ready_full;
   assign idle_sts     = (blocked_fill_ff != '0) ? STS_ONLY_BLOCKED : STS_NO_JOBS;

   assign sts.io_pending = (op_ff == OP_IO_DONE) && (blocked_fill_ff != '0);
   assign sts.can_move   = can_move;

   always_comb begin
      op_in           = op_ff;
      job_in          = job_ff;
      ready_head_in   = ready_head_ff;
      ready_fill_in   = ready_fill_ff;
      blocked_head_in = blocked_head_ff;
      blocked_fill_in = blocked_fill_ff;
      slot_job_in     = slot_job_ff;
      slot_mode_in    = slot_mode_ff;
      status_in       = status_ff;
      ready_we        = 1'b0;
      ready_wa        = ptr_add(ready_head_ff, ready_fill_ff);
      ready_wd        = job_ff;
      blocked_we      = 1'b0;
      blocked_wa      = ptr_add(blocked_head_ff, blocked_fill_ff);
      blocked_wd      = slot_job_ff;
      blocked_wd.ticks = '0;
      blocked_wd.io    = 1'b0;

      if (cmd.accept) begin
         op_in        = op_type'(req_operation);
         job_in.id    = req_job_id;
         job_in.start = req_job_start;
         job_in.ticks = req_job_cpu_ticks;
         job_in.io    = req_job_wants_io;
      end

      if (cmd.exec) begin
         unique case (op_ff)
            OP_ADD: begin
               if (ready_full) begin
                  status_in = STS_QUEUE_FULL;
               end else begin
                  ready_we      = 1'b1;
                  ready_fill_in = ready_fill_ff + CNT_ONE;
                  status_in     = STS_ADDED;
               end
            end
            OP_TICK: begin
               unique case (slot_mode_ff)
                  SLOT_EMPTY: begin
                     if (ready_fill_ff == '0) begin
                        status_in = idle_sts;
                     end else begin
                        slot_job_in   = rd_ready_ff;
                        ready_head_in = ptr_add(ready_head_ff, CNT_ONE);
                        ready_fill_in = ready_fill_ff - CNT_ONE;
                        slot_mode_in  = SLOT_ACTIVE;
                        status_in     = STS_LOADED;
                     end
                  end
                  SLOT_ACTIVE: begin
                     if (slot_job_ff.ticks > TICK_ONE) begin
                        slot_job_in.ticks = slot_job_ff.ticks - TICK_ONE;
                        status_in         = STS_DECREMENTED;
                     end else begin
                        // The burst ends now, whether one tick or none was left.
                        slot_job_in.ticks = '0;
                        if (slot_job_ff.io) begin
                           if (blocked_full) begin
                              status_in = STS_QUEUE_FULL;
                           end else begin
                              blocked_we      = 1'b1;
                              blocked_fill_in = blocked_fill_ff + CNT_ONE;
                              slot_job_in.io  = 1'b0;
                              slot_mode_in    = SLOT_RETIRED;
                              status_in       = STS_TO_BLOCKED;
                           end
                        end else begin
                           slot_mode_in = SLOT_RETIRED;
                           status_in    = STS_FINISHED;
                        end
                     end
                  end
                  default: begin
                     slot_job_in  = '0;
                     slot_mode_in = SLOT_EMPTY;
                     status_in    = STS_NO_JOBS;
                  end
               endcase
            end
            OP_SWITCH: begin
               if (ready_fill_ff == '0) begin
                  status_in = idle_sts;
               end else begin
                  slot_job_in   = rd_ready_ff;
                  ready_head_in = ptr_add(ready_head_ff, CNT_ONE);
                  slot_mode_in  = SLOT_ACTIVE;
                  status_in     = STS_SWITCHED;
                  // An active job goes back to the tail; the pop made room.
                  if (slot_mode_ff == SLOT_ACTIVE) begin
                     ready_we = 1'b1;
                     ready_wd = slot_job_ff;
                  end else begin
                     ready_fill_in = ready_fill_ff - CNT_ONE;
                  end
               end
            end
            OP_IO_DONE: begin
               if (blocked_fill_ff == '0) begin
                  status_in = STS_BLOCKED_EMPTY;
               end
            end
            default: begin
               status_in = STS_UNKNOWN_IRQ;
            end
         endcase
      end

      if (cmd.move) begin
         if (can_move) begin
            ready_we        = 1'b1;
            ready_wd        = rd_blocked_ff;
            ready_fill_in   = ready_fill_ff + CNT_ONE;
            blocked_head_in = ptr_add(blocked_head_ff, CNT_ONE);
            blocked_fill_in = blocked_fill_ff - CNT_ONE;
         end else begin
            status_in = (blocked_fill_ff != '0) ? STS_QUEUE_FULL : STS_BLOCKED_MOVED;
         end
      end
   end

   // Both stores are read at the next head, so the head entry is waiting
   // in a register from the cycle after the head moves.
   always_ff @(posedge clock) begin
      rd_ready_ff <= ready_mem[ready_head_in];
      if (ready_we) begin
         ready_mem[ready_wa] <= ready_wd;
      end
   end

   always_ff @(posedge clock) begin
      rd_blocked_ff <= blocked_mem[blocked_head_in];
      if (blocked_we) begin
         blocked_mem[blocked_wa] <= blocked_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_head_ff   <= '0;
         ready_fill_ff   <= '0;
         blocked_head_ff <= '0;
         blocked_fill_ff <= '0;
         slot_job_ff     <= '0;
         slot_mode_ff    <= SLOT_EMPTY;
      end else begin
         ready_head_ff   <= ready_head_in;
         ready_fill_ff   <= ready_fill_in;
         blocked_head_ff <= blocked_head_in;
         blocked_fill_ff <= blocked_fill_in;
         slot_job_ff     <= slot_job_in;
         slot_mode_ff    <= slot_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      job_ff    <= job_in;
      status_ff <= status_in;
      if (cmd.load_rsp) begin
         rsp_status_ff        <= status_ff;
         rsp_slot_mode_ff     <= slot_mode_ff;
         rsp_job_ff           <= slot_job_ff;
         rsp_ready_count_ff   <= ready_fill_ff;
         rsp_blocked_count_ff <= blocked_fill_ff;
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_mode     = rsp_slot_mode_ff;
   assign rsp_cur_id        = rsp_job_ff.id;
   assign rsp_cur_start     = rsp_job_ff.start;
   assign rsp_cur_cpu_ticks = rsp_job_ff.ticks;
   assign rsp_cur_wants_io  = rsp_job_ff.io;
   assign rsp_ready_count   = rsp_ready_count_ff;
   assign rsp_blocked_count = rsp_blocked_count_ff;

   `RBJD_ASSERT(a_fill_bound, clock, reset, (ready_fill_ff <= CNT_DEPTH) && (blocked_fill_ff <= CNT_DEPTH), "queue fill above depth")
   `RBJD_ASSERT(a_move_conserves, clock, reset, cmd.move |=> ((ready_fill_ff + blocked_fill_ff) == $past(ready_fill_ff + blocked_fill_ff)), "job lost or duplicated in move")
   `RBJD_ASSERT(a_move_into_room, clock, reset, (cmd.move && can_move) |-> !ready_full, "move into a full ready queue")
   `RBJD_ASSERT(a_empty_slot_zero, clock, reset, (slot_mode_ff == SLOT_EMPTY) |-> (slot_job_ff == '0), "empty slot holds stale job")

endmodule

// ===== hw/rtl/rbjd_controller.sv =====
// ============================================================================
// Job dispatcher controller
// Sequences accept, execute, blocked-queue moves and the result transfer.
// ============================================================================
`include "ready_blocked_job_dispatcher_top_macros.svh"

module rbjd_controller
   import rbjd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type sts,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != CTL_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.io_pending ? CTL_MOVE : CTL_RESP;
         end
         CTL_MOVE: begin
            cmd.move = 1'b1;
            if (!sts.can_move) begin
               state_in = CTL_RESP;
            end
         end
         CTL_RESP: begin
            // The result register is free when empty or being taken now.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
   end

   `RBJD_ASSERT(a_accept_to_exec, clock, reset, (req_valid && !req_stall) |=> (state_ff == CTL_EXEC), "accepted item not executed")
   `RBJD_ASSERT(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == CTL_RESP), "result shown outside result step")
   `RBJD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> ((state_ff == CTL_IDLE) && !rsp_valid_ff), "reset left controller busy")

endmodule

// ===== hw/rtl/ready_blocked_job_dispatcher_top.sv =====
// ============================================================================
// Ready/blocked job dispatcher
// Items are taken one at a time: a new item is accepted only after the
// previous one has passed the accept, execute and result steps of the
// controller; io-complete also moves blocked jobs, one entry per cycle.
// Reset (synchronous, active high) empties both queues and the running slot.
// ============================================================================
module ready_blocked_job_dispatcher_top
   import rbjd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_operation,
   input  logic [ID_BITS-1:0]   req_job_id,
   input  logic [TICK_BITS-1:0] req_job_start,
   input  logic [TICK_BITS-1:0] req_job_cpu_ticks,
   input  logic                 req_job_wants_io,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [3:0]           rsp_status,
   output logic [1:0]           rsp_slot_mode,
   output logic [ID_BITS-1:0]   rsp_cur_id,
   output logic [TICK_BITS-1:0] rsp_cur_start,
   output logic [TICK_BITS-1:0] rsp_cur_cpu_ticks,
   output logic                 rsp_cur_wants_io,
   output logic [CNT_BITS-1:0]  rsp_ready_count,
   output logic [CNT_BITS-1:0]  rsp_blocked_count
);

   // The controller and the datapath talk only through these two groups.
   // Commands say which step runs this cycle; status tells the controller
   // whether an io-complete still has blocked jobs to move.
   dp_cmd_type    cmd;
   dp_status_type sts;

   // The controller owns both handshakes. An item is taken only while the
   // controller is idle, but the result register keeps the previous result
   // until its transfer completes, so a new item can be worked on while the
   // downstream side is still stalling.
   rbjd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the two circular queues in small memories with
   // registered reads, the running slot, and the result payload register.
   // Each result carries a snapshot of the slot and both fill counts taken
   // after the operation has finished.
   rbjd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_job_id        (req_job_id),
      .req_job_start     (req_job_start),
      .req_job_cpu_ticks (req_job_cpu_ticks),
      .req_job_wants_io  (req_job_wants_io),
      .rsp_status        (rsp_status),
      .rsp_slot_mode     (rsp_slot_mode),
      .rsp_cur_id        (rsp_cur_id),
      .rsp_cur_start     (rsp_cur_start),
      .rsp_cur_cpu_ticks (rsp_cur_cpu_ticks),
      .rsp_cur_wants_io  (rsp_cur_wants_io),
      .rsp_ready_count   (rsp_ready_count),
      .rsp_blocked_count (rsp_blocked_count)
   );

endmodule

// ===== verif/tb_ready_blocked_job_dispatcher_top.sv =====
// ============================================================================
// Testbench for the ready/blocked job dispatcher
// A table of directed operations runs first, then segments of random traffic
// with different operation mixes. Every transfer in is run through a local
// model of the two queues and the running slot, and every transfer out is
// compared field by field with the oldest prediction.
// ============================================================================
module tb_ready_blocked_job_dispatcher_top;
   import rbjd_pkg::*;

   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 7;
   localparam int RANDOM_ITEMS   = 1470;
   localparam int QUIET_ITEMS    = 200;
   localparam int DRAIN_CYCLES   = 2 * QUEUE_DEPTH + 8;
   localparam int TIMEOUT_CYCLES = 600000;

   // Operation codes above OP_OTHER are unused; the block treats them all as
   // an unknown interrupt.
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   // Index of each queue in the predictor's storage.
   localparam int READY_IDX   = 0;
   localparam int BLOCKED_IDX = 1;

   // One result transfer as the block presents it.
   typedef struct packed {
      status_type           status;
      slot_type             mode;
      logic [ID_BITS-1:0]   id;
      logic [TICK_BITS-1:0] start;
      logic [TICK_BITS-1:0] ticks;
      logic                 io;
      logic [CNT_BITS-1:0]  ready_cnt;
      logic [CNT_BITS-1:0]  blocked_cnt;
   } result_type;

   // One row of the directed table. Rows with a typed result carry it in
   // res; the others are checked against the predictor.
   typedef struct {
      logic [2:0] op;
      job_type    job;
      int         rep;
      bit         typed;
      result_type res;
   } plan_row_type;

   // Operation mixes of the random part.
   typedef enum {
      MIX_TRAFFIC,
      IO_FILL_TRAFFIC,
      DRAIN_TRAFFIC
   } traffic_type;

   // -------------------------------------------------------------------------
   // Block ports. Everything the testbench drives starts at a known value.
   // -------------------------------------------------------------------------
   logic                 clock;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_stall;
   logic [2:0]           req_operation     = OP_ADD;
   logic [ID_BITS-1:0]   req_job_id        = '0;
   logic [TICK_BITS-1:0] req_job_start     = '0;
   logic [TICK_BITS-1:0] req_job_cpu_ticks = '0;
   logic                 req_job_wants_io  = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall         = 1'b0;
   logic [3:0]           rsp_status;
   logic [1:0]           rsp_slot_mode;
   logic [ID_BITS-1:0]   rsp_cur_id;
   logic [TICK_BITS-1:0] rsp_cur_start;
   logic [TICK_BITS-1:0] rsp_cur_cpu_ticks;
   logic                 rsp_cur_wants_io;
   logic [CNT_BITS-1:0]  rsp_ready_count;
   logic [CNT_BITS-1:0]  rsp_blocked_count;

   ready_blocked_job_dispatcher_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_job_id        (req_job_id),
      .req_job_start     (req_job_start),
      .req_job_cpu_ticks (req_job_cpu_ticks),
      .req_job_wants_io  (req_job_wants_io),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_slot_mode     (rsp_slot_mode),
      .rsp_cur_id        (rsp_cur_id),
      .rsp_cur_start     (rsp_cur_start),
      .rsp_cur_cpu_ticks (rsp_cur_cpu_ticks),
      .rsp_cur_wants_io  (rsp_cur_wants_io),
      .rsp_ready_count   (rsp_ready_count),
      .rsp_blocked_count (rsp_blocked_count)
   );

   always begin
      clock = 1'b0;
      #(CLK_PERIOD / 2);
      clock = 1'b1;
      #(CLK_PERIOD / 2);
   end

   // -------------------------------------------------------------------------
   // Predictor state: both queues as circular stores, and the running slot.
   // Only entries that were pushed are ever popped, so the stores need no
   // reset value.
   // -------------------------------------------------------------------------
   job_type  queue_mem [2][QUEUE_DEPTH];
   int       queue_head [2];
   int       queue_fill [2];
   job_type  slot_job;
   slot_type slot_state;

   // Results still owed by the block, oldest first.
   result_type owed_results[$];

   int       mismatch_count = 0;
   int       items_sent     = 0;
   int       directed_items = 0;
   int       results_seen   = 0;
   bit [15:0] status_seen   = '0;

   // Idling control: the sender idles only while send_idle_on is set, and
   // the final stretch of the run sets quiet to switch off idling on both
   // sides.
   bit       send_idle_on = 1'b0;
   bit       quiet        = 1'b0;
   int       stall_left   = 0;
   int       run_left     = 0;

   plan_row_type plan[$];

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t: mismatch: %s", $time, msg);
   endtask

   function automatic bit queue_push(input int q, input job_type j);
      if (queue_fill[q] >= QUEUE_DEPTH) begin
         return 1'b0;
      end
      queue_mem[q][(queue_head[q] + queue_fill[q]) % QUEUE_DEPTH] = j;
      queue_fill[q]++;
      return 1'b1;
   endfunction

   function automatic job_type queue_pop(input int q);
      job_type j;
      j = queue_mem[q][queue_head[q]];
      queue_head[q] = (queue_head[q] + 1) % QUEUE_DEPTH;
      queue_fill[q]--;
      return j;
   endfunction

   // With no job to run, the status tells whether anything waits on io.
   function automatic status_type idle_status();
      return (queue_fill[BLOCKED_IDX] > 0) ? STS_ONLY_BLOCKED : STS_NO_JOBS;
   endfunction

   // Applies one operation to the predictor state and returns the result
   // that the block is to produce for it.
   function automatic result_type dispatch_predict(input logic [2:0] op, input job_type j);
      result_type res;
      status_type st;
      job_type    moved;
      job_type    nxt;
      bit         counting;
      counting = 1'b0;
      case (op)
         OP_ADD: begin
            st = queue_push(READY_IDX, j) ? STS_ADDED : STS_QUEUE_FULL;
         end
         OP_TICK: begin
            if (slot_state == SLOT_EMPTY) begin
               if (queue_fill[READY_IDX] == 0) begin
                  st = idle_status();
               end else begin
                  slot_job   = queue_pop(READY_IDX);
                  slot_state = SLOT_ACTIVE;
                  st         = STS_LOADED;
               end
            end else if (slot_state != SLOT_ACTIVE) begin
               // A retired slot is cleared.
               slot_job   = '0;
               slot_state = SLOT_EMPTY;
               st         = STS_NO_JOBS;
            end else begin
               // A job with zero ticks left is not counted down; its burst
               // ends on this tick.
               if (slot_job.ticks != '0) begin
                  slot_job.ticks = slot_job.ticks - TICK_ONE;
                  counting       = (slot_job.ticks != '0);
               end
               if (counting) begin
                  st = STS_DECREMENTED;
               end else if (slot_job.io) begin
                  moved    = slot_job;
                  moved.io = 1'b0;
                  if (!queue_push(BLOCKED_IDX, moved)) begin
                     // The job stays active and retries on the next tick.
                     st = STS_QUEUE_FULL;
                  end else begin
                     slot_job.io = 1'b0;
                     slot_state  = SLOT_RETIRED;
                     st          = STS_TO_BLOCKED;
                  end
               end else begin
                  slot_state = SLOT_RETIRED;
                  st         = STS_FINISHED;
               end
            end
         end
         OP_SWITCH: begin
            if (queue_fill[READY_IDX] == 0) begin
               st = idle_status();
            end else begin
               // Only an active job goes back; a retired one is dropped.
               nxt = queue_pop(READY_IDX);
               if (slot_state == SLOT_ACTIVE) begin
                  void'(queue_push(READY_IDX, slot_job));
               end
               slot_job   = nxt;
               slot_state = SLOT_ACTIVE;
               st         = STS_SWITCHED;
            end
         end
         OP_IO_DONE: begin
            if (queue_fill[BLOCKED_IDX] == 0) begin
               st = STS_BLOCKED_EMPTY;
            end else begin
               while (queue_fill[BLOCKED_IDX] > 0 && queue_fill[READY_IDX] < QUEUE_DEPTH) begin
                  moved = queue_pop(BLOCKED_IDX);
                  void'(queue_push(READY_IDX, moved));
               end
               st = (queue_fill[BLOCKED_IDX] > 0) ? STS_QUEUE_FULL : STS_BLOCKED_MOVED;
            end
         end
         default: begin
            st = STS_UNKNOWN_IRQ;
         end
      endcase
      res.status      = st;
      res.mode        = slot_state;
      res.id          = slot_job.id;
      res.start       = slot_job.start;
      res.ticks       = slot_job.ticks;
      res.io          = slot_job.io;
      res.ready_cnt   = CNT_BITS'(queue_fill[READY_IDX]);
      res.blocked_cnt = CNT_BITS'(queue_fill[BLOCKED_IDX]);
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Directed table helpers.
   // -------------------------------------------------------------------------
   function automatic plan_row_type step_row(input logic [2:0] op,
                                             input logic [ID_BITS-1:0] id,
                                             input logic [TICK_BITS-1:0] start,
                                             input logic [TICK_BITS-1:0] ticks,
                                             input logic io, input int rep);
      plan_row_type row;
      row.op        = op;
      row.job.id    = id;
      row.job.start = start;
      row.job.ticks = ticks;
      row.job.io    = io;
      row.rep       = rep;
      row.typed     = 1'b0;
      row.res       = '0;
      return row;
   endfunction

   // A row whose result is known outright: the slot is empty, so only the
   // status and the two counts carry information.
   function automatic plan_row_type fixed_row(input logic [2:0] op,
                                              input logic [ID_BITS-1:0] id,
                                              input logic [TICK_BITS-1:0] start,
                                              input logic [TICK_BITS-1:0] ticks,
                                              input logic io, input status_type st,
                                              input int ready_cnt, input int blocked_cnt);
      plan_row_type row;
      row                 = step_row(op, id, start, ticks, io, 1);
      row.typed           = 1'b1;
      row.res.status      = st;
      row.res.mode        = SLOT_EMPTY;
      row.res.ready_cnt   = CNT_BITS'(ready_cnt);
      row.res.blocked_cnt = CNT_BITS'(blocked_cnt);
      return row;
   endfunction

   // -------------------------------------------------------------------------
   // Request side. The payload is driven at a rising edge and held until the
   // transfer completes at an edge where req_stall is low. Each transfer is
   // run through the predictor at the edge that accepts it.
   // -------------------------------------------------------------------------
   task automatic send_op(input logic [2:0] op, input job_type j, input bit typed,
                          input result_type typed_res);
      result_type predicted;
      if (send_idle_on && !quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_job_id        <= j.id;
      req_job_start     <= j.start;
      req_job_cpu_ticks <= j.ticks;
      req_job_wants_io  <= j.io;
      do @(posedge clock); while (req_stall);
      // The predictor always advances, even where the row types its result.
      predicted = dispatch_predict(op, j);
      owed_results.push_back(typed ? typed_res : predicted);
      items_sent++;
   endtask

   // One random operation in the given mix. Fields the operation ignores
   // are randomized as well.
   task automatic send_random(input traffic_type mix);
      logic [2:0] op;
      job_type    j;
      int         pick;
      int         size_pick;
      pick      = $urandom_range(0, 99);
      size_pick = $urandom_range(0, 99);
      j.id      = ID_BITS'($urandom);
      j.start   = TICK_BITS'($urandom);
      // Short bursts keep jobs moving; a few jobs get a huge burst and sit
      // in the slot until a switch rotates them out.
      if (size_pick < 65) begin
         j.ticks = TICK_BITS'($urandom_range(0, 3));
      end else if (size_pick < 96) begin
         j.ticks = TICK_BITS'($urandom_range(0, 40));
      end else begin
         j.ticks = TICK_BITS'($urandom);
      end
      j.io = 1'($urandom_range(0, 1));
      case (mix)
         IO_FILL_TRAFFIC: begin
            // No io-complete here, so the blocked queue fills up.
            if (pick < 35) begin
               op   = OP_ADD;
               j.io = ($urandom_range(0, 9) != 0);
            end else if (pick < 93) begin
               op = OP_TICK;
            end else if (pick < 97) begin
               op = OP_SWITCH;
            end else begin
               op = 3'($urandom_range(OP_OTHER, OP_UNUSED_HI));
            end
         end
         DRAIN_TRAFFIC: begin
            // Many adds and io-completes, so the ready queue fills while
            // blocked jobs are moved over.
            if (pick < 40) begin
               op = OP_ADD;
            end else if (pick < 65) begin
               op = OP_IO_DONE;
            end else if (pick < 90) begin
               op = OP_TICK;
            end else begin
               op = OP_SWITCH;
            end
         end
         default: begin
            if (pick < 30) begin
               op = OP_ADD;
            end else if (pick < 65) begin
               op = OP_TICK;
            end else if (pick < 77) begin
               op = OP_SWITCH;
            end else if (pick < 90) begin
               op = OP_IO_DONE;
            end else begin
               op = 3'($urandom_range(OP_OTHER, OP_UNUSED_HI));
            end
         end
      endcase
      send_op(op, j, 1'b0, '0);
   endtask

   // -------------------------------------------------------------------------
   // Result side stall: stall bursts of random length separated by random
   // runs, some of them long. The quiet stretch at the end has no stalls.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) begin
            rsp_stall <= 1'b0;
         end
      end else if (run_left > 0) begin
         run_left--;
      end else begin
         if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 18);
            rsp_stall <= 1'b1;
         end
         run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(0, 30);
      end
   end

   // -------------------------------------------------------------------------
   // Result checker. A result transfer takes place at an edge where rsp_valid
   // is high and rsp_stall is low; it is matched with the oldest prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      result_type want;
      string      bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         status_seen[rsp_status] = 1'b1;
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing owed, status %0d",
                                      results_seen, rsp_status));
         end else begin
            want = owed_results.pop_front();
            bad  = "";
            if (rsp_status !== want.status) begin
               bad = {bad, $sformatf(" status %0d/%0d", rsp_status, want.status)};
            end
            if (rsp_slot_mode !== want.mode) begin
               bad = {bad, $sformatf(" slot_mode %0d/%0d", rsp_slot_mode, want.mode)};
            end
            if (rsp_cur_id !== want.id) begin
               bad = {bad, $sformatf(" cur_id %h/%h", rsp_cur_id, want.id)};
            end
            if (rsp_cur_start !== want.start) begin
               bad = {bad, $sformatf(" cur_start %h/%h", rsp_cur_start, want.start)};
            end
            if (rsp_cur_cpu_ticks !== want.ticks) begin
               bad = {bad, $sformatf(" cur_cpu_ticks %h/%h", rsp_cur_cpu_ticks, want.ticks)};
            end
            if (rsp_cur_wants_io !== want.io) begin
               bad = {bad, $sformatf(" cur_wants_io %b/%b", rsp_cur_wants_io, want.io)};
            end
            if (rsp_ready_count !== want.ready_cnt) begin
               bad = {bad, $sformatf(" ready_count %0d/%0d", rsp_ready_count,
                                     want.ready_cnt)};
            end
            if (rsp_blocked_count !== want.blocked_cnt) begin
               bad = {bad, $sformatf(" blocked_count %0d/%0d", rsp_blocked_count,
                                     want.blocked_cnt)};
            end
            if (bad != "") begin
               report_mismatch($sformatf("result %0d (got/want):%s", results_seen, bad));
            end
         end
         results_seen++;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin : main_flow
      traffic_type mix;
      job_type     j;
      int          seg_left;
      int          k;
      queue_head = '{0, 0};
      queue_fill = '{0, 0};
      slot_job   = '0;
      slot_state = SLOT_EMPTY;

      // Everything on an idle block after reset, then the extremes of the
      // job fields.
      plan.push_back(fixed_row(OP_TICK, '0, '0, '0, 1'b0, STS_NO_JOBS, 0, 0));
      plan.push_back(fixed_row(OP_SWITCH, '1, '1, '1, 1'b1, STS_NO_JOBS, 0, 0));
      plan.push_back(fixed_row(OP_IO_DONE, '0, '0, '0, 1'b0, STS_BLOCKED_EMPTY, 0, 0));
      plan.push_back(fixed_row(OP_OTHER, '1, '1, '1, 1'b1, STS_UNKNOWN_IRQ, 0, 0));
      plan.push_back(fixed_row(OP_UNUSED_HI, '0, '0, '0, 1'b0, STS_UNKNOWN_IRQ, 0, 0));
      plan.push_back(fixed_row(OP_ADD, '1, '1, '1, 1'b1, STS_ADDED, 1, 0));
      plan.push_back(fixed_row(OP_ADD, '0, '0, '0, 1'b0, STS_ADDED, 2, 0));
      plan.push_back(step_row(OP_ADD, 16'h1234, 16'h0005, 16'h0001, 1'b1, 1));
      // Load the all-ones job, switch it out for the zero-tick job, which
      // finishes on the next tick; the retired slot is then cleared.
      plan.push_back(step_row(OP_TICK, '0, '0, '0, 1'b0, 1));
      plan.push_back(step_row(OP_SWITCH, '0, '0, '0, 1'b0, 1));
      plan.push_back(step_row(OP_TICK, '0, '0, '0, 1'b0, 1));
      plan.push_back(step_row(OP_TICK, '0, '0, '0, 1'b0, 1));
      // The one-tick io job goes to the blocked queue, a switch drops the
      // retired slot, and io-complete brings the job back.
      plan.push_back(step_row(OP_TICK, '0, '0, '0, 1'b0, 2));
      plan.push_back(step_row(OP_SWITCH, '0, '0, '0, 1'b0, 1));
      plan.push_back(step_row(OP_IO_DONE, '0, '0, '0, 1'b0, 1));
      plan.push_back(step_row(OP_SWITCH, '0, '0, '0, 1'b0, 1));
      // Overfill the ready queue, so the last adds are refused, then rotate
      // with the queue full.
      plan.push_back(step_row(OP_ADD, 16'h0100, 16'h8000, 16'h0002, 1'b1, 17));
      plan.push_back(step_row(OP_SWITCH, '0, '0, '0, 1'b0, 2));
      // Run the short io jobs into the blocked queue.
      plan.push_back(step_row(OP_TICK, '0, '0, '0, 1'b0, 70));
      plan.push_back(step_row(OP_ADD, 16'h0200, 16'h7FFF, 16'h0000, 1'b0, 16));
      plan.push_back(step_row(OP_TICK, '0, '0, '0, 1'b0, 6));
      // Io-complete with little or no room left in the ready queue.
      plan.push_back(step_row(OP_IO_DONE, '0, '0, '0, 1'b0, 2));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_idle_on = 1'b1;
      foreach (plan[r]) begin
         for (k = 0; k < plan[r].rep; k++) begin
            j = plan[r].job;
            if (plan[r].op == OP_ADD) begin
               j.id = j.id + ID_BITS'(k);
            end
            send_op(plan[r].op, j, plan[r].typed, plan[r].res);
         end
      end
      directed_items = items_sent;

      // Random segments, each with its own operation mix and its own choice
      // of whether the sender idles.
      k = 0;
      while (k < RANDOM_ITEMS) begin
         mix          = traffic_type'($urandom_range(0, 2));
         send_idle_on = ($urandom_range(0, 9) >= 3);
         seg_left     = $urandom_range(20, 90);
         while (seg_left > 0 && k < RANDOM_ITEMS) begin
            if (k == RANDOM_ITEMS - QUIET_ITEMS) begin
               quiet = 1'b1;
            end
            send_random(mix);
            seg_left--;
            k++;
         end
      end

      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      // Let any stray result show up before the final verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);

      while (owed_results.size() != 0) begin
         void'(owed_results.pop_front());
         report_mismatch("predicted result never arrived");
      end

      $display("Covered %0d operations (%0d from the directed table) and %0d results,",
               items_sent, directed_items, results_seen);
      $display("with %0d of 12 status codes returned and %0d mismatches.",
               $countones(status_seen[11:0]), mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_ready_blocked_job_dispatcher_top: PASS");
      end else begin
         $display("tb_ready_blocked_job_dispatcher_top: FAIL");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Timed out with %0d results still owed.", owed_results.size());
      $display("tb_ready_blocked_job_dispatcher_top: FAIL");
      $finish;
   end

endmodule
